// File: rtl/core/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg
// Shared widths, register indexes, command/status types and helpers for the
// matrix saddle point finder.
// ----------------------------------------------------------------------------
package msp_pkg;

  localparam int DATA_W       = 32;
  localparam int CNT_W        = 4;
  localparam int IDX_W        = 3;
  localparam int CFG_IDX_W    = 2;
  localparam int MAX_ROWS_DEF = 8;
  localparam int MAX_COLS_DEF = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

  typedef struct packed {
    logic             load_en;
    logic             first_row;
    logic             first_col;
    logic             rd_en;
    logic             cmp_take;
    logic             finish;
    logic             scan_start;
    logic [IDX_W-1:0] row_idx;
    logic [IDX_W-1:0] col_idx;
  } msp_cmd_t;

  typedef struct packed {
    logic match;
    logic pend_valid;
    logic out_busy;
  } msp_status_t;

  // A size of zero counts as one; sizes above the maximum saturate.
  function automatic logic [CNT_W-1:0] clamp_size(input logic [CNT_W-1:0] v,
                                                  input logic [CNT_W-1:0] maxv);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/matrix_saddle_point_finder.sv
// ----------------------------------------------------------------------------
// matrix_saddle_point_finder
// Loads a matrix in row-major order and reports every element that is both
// its row minimum and its column maximum.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake          Contents
//  in_      input      valid / stall      element_value
//  out_     output     valid / stall      point_value, point_row, point_col,
//                                         none_found, run_last
//  cfg_     input      valid / ready      index (0 row_count, 1 col_count), data
//
//  Elements are taken one per cycle while loading; the extremes update as
//  each element is written into the element memory.
//  The element that completes the matrix starts a scan: each element is
//  first read from the element memory and then compared.
//  While the scan runs, in_stall is high and cfg_ready is low. in_stall is
//  also high in any cycle where cfg_valid is high.
//  out_stall holds the scan whenever a result cannot move into the output
//  register. Reset sets both sizes to 1 and the load pointer to the first
//  element; the memory is not cleared.
// ----------------------------------------------------------------------------
module matrix_saddle_point_finder #(
  parameter int MAX_ROWS = msp_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = msp_pkg::MAX_COLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [msp_pkg::DATA_W-1:0] in_element_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [msp_pkg::DATA_W-1:0] out_point_value,
  output logic [msp_pkg::CNT_W-1:0]         out_point_row,
  output logic [msp_pkg::CNT_W-1:0]         out_point_col,
  output logic                              out_none_found,
  output logic                              out_run_last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [msp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [msp_pkg::CNT_W-1:0]         cfg_data
);
  import msp_pkg::*;

  msp_cmd_t    cmd;
  msp_status_t status;

  msp_ctrl #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .cmd       (cmd)
  );

  msp_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .in_element_value (in_element_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_point_value  (out_point_value),
    .out_point_row    (out_point_row),
    .out_point_col    (out_point_col),
    .out_none_found   (out_none_found),
    .out_run_last     (out_run_last)
  );

endmodule

// File: rtl/core/msp_ctrl.sv
// ----------------------------------------------------------------------------
// msp_ctrl
// Controller: size registers, load pointer, scan counters and the state
// machine that sequences loading, scanning and the closing result.
// ----------------------------------------------------------------------------
module msp_ctrl #(
  parameter int MAX_ROWS = msp_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = msp_pkg::MAX_COLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [msp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msp_pkg::CNT_W-1:0]      cfg_data,
  input  msp_pkg::msp_status_t           status,
  output msp_pkg::msp_cmd_t              cmd
);
  import msp_pkg::*;

  localparam logic [1:0] ST_LOAD     = 2'd0;
  localparam logic [1:0] ST_SCAN_RD  = 2'd1;
  localparam logic [1:0] ST_SCAN_CMP = 2'd2;
  localparam logic [1:0] ST_SCAN_END = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] row_count_r, row_count_nxt;
  logic [CNT_W-1:0] col_count_r, col_count_nxt;
  logic [IDX_W-1:0] lr_r, lr_nxt, lc_r, lc_nxt;
  logic [IDX_W-1:0] sr_r, sr_nxt, sc_r, sc_nxt;

  logic [CNT_W-1:0] rc, cc;
  logic [IDX_W-1:0] use_r, use_c;
  logic             in_acc, cfg_acc;
  logic             load_last_col, load_last_row;
  logic             scan_last_col, scan_last_row;

  assign rc = clamp_size(row_count_r, CNT_W'(MAX_ROWS));
  assign cc = clamp_size(col_count_r, CNT_W'(MAX_COLS));

  // An offered configuration write holds the input off so both never land together.
  assign in_stall  = (state_r != ST_LOAD) || cfg_valid;
  assign cfg_ready = (state_r == ST_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // A pointer outside the current size starts over at the first element.
  always_comb begin
    if ((CNT_W'(lr_r) >= rc) || (CNT_W'(lc_r) >= cc)) begin
      use_r = '0;
      use_c = '0;
    end else begin
      use_r = lr_r;
      use_c = lc_r;
    end
  end

  assign load_last_col = (CNT_W'(use_c) == cc - CNT_W'(1));
  assign load_last_row = (CNT_W'(use_r) == rc - CNT_W'(1));
  assign scan_last_col = (CNT_W'(sc_r) == cc - CNT_W'(1));
  assign scan_last_row = (CNT_W'(sr_r) == rc - CNT_W'(1));

  always_comb begin
    state_nxt     = state_r;
    row_count_nxt = row_count_r;
    col_count_nxt = col_count_r;
    lr_nxt        = lr_r;
    lc_nxt        = lc_r;
    sr_nxt        = sr_r;
    sc_nxt        = sc_r;
    cmd           = '0;

    case (state_r)
      ST_LOAD: begin
        cmd.row_idx   = use_r;
        cmd.col_idx   = use_c;
        cmd.first_row = (use_r == '0);
        cmd.first_col = (use_c == '0);
        if (cfg_acc && (cfg_index == REG_ROW_COUNT || cfg_index == REG_COL_COUNT)) begin
          if (cfg_index == REG_ROW_COUNT) begin
            row_count_nxt = cfg_data;
          end else begin
            col_count_nxt = cfg_data;
          end
          lr_nxt = '0;
          lc_nxt = '0;
        end else if (in_acc) begin
          cmd.load_en = 1'b1;
          if (load_last_col) begin
            lc_nxt = '0;
            if (load_last_row) begin
              lr_nxt         = '0;
              sr_nxt         = '0;
              sc_nxt         = '0;
              cmd.scan_start = 1'b1;
              state_nxt      = ST_SCAN_RD;
            end else begin
              lr_nxt = use_r + IDX_W'(1);
            end
          end else begin
            lr_nxt = use_r;
            lc_nxt = use_c + IDX_W'(1);
          end
        end
      end
      ST_SCAN_RD: begin
        cmd.row_idx = sr_r;
        cmd.col_idx = sc_r;
        cmd.rd_en   = 1'b1;
        state_nxt   = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        cmd.row_idx = sr_r;
        cmd.col_idx = sc_r;
        // A new match pushes the held one out; wait while the output is full.
        if (!(status.match && status.pend_valid && status.out_busy)) begin
          cmd.cmp_take = 1'b1;
          if (scan_last_col) begin
            sc_nxt = '0;
            if (scan_last_row) begin
              state_nxt = ST_SCAN_END;
            end else begin
              sr_nxt    = sr_r + IDX_W'(1);
              state_nxt = ST_SCAN_RD;
            end
          end else begin
            sc_nxt    = sc_r + IDX_W'(1);
            state_nxt = ST_SCAN_RD;
          end
        end
      end
      ST_SCAN_END: begin
        if (!status.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      row_count_r <= CNT_W'(1);
      col_count_r <= CNT_W'(1);
      lr_r        <= '0;
      lc_r        <= '0;
      sr_r        <= '0;
      sc_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      row_count_r <= row_count_nxt;
      col_count_r <= col_count_nxt;
      lr_r        <= lr_nxt;
      lc_r        <= lc_nxt;
      sr_r        <= sr_nxt;
      sc_r        <= sc_nxt;
    end
  end

endmodule

// File: rtl/core/msp_dp.sv
// ----------------------------------------------------------------------------
// msp_dp
// Datapath: element memory, row minimum and column maximum registers,
// scan compare, one held match and the output register.
// ----------------------------------------------------------------------------
module msp_dp #(
  parameter int MAX_ROWS = msp_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = msp_pkg::MAX_COLS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  msp_pkg::msp_cmd_t                 cmd,
  output msp_pkg::msp_status_t              status,
  input  logic signed [msp_pkg::DATA_W-1:0] in_element_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [msp_pkg::DATA_W-1:0] out_point_value,
  output logic [msp_pkg::CNT_W-1:0]         out_point_row,
  output logic [msp_pkg::CNT_W-1:0]         out_point_col,
  output logic                              out_none_found,
  output logic                              out_run_last
);
  import msp_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] row_min_r [MAX_ROWS];
  logic signed [DATA_W-1:0] col_max_r [MAX_COLS];
  logic signed [DATA_W-1:0] cur_min_r;
  logic signed [DATA_W-1:0] rd_data_r;

  logic [RW-1:0]            ridx;
  logic [CW-1:0]            cidx;
  logic [AW-1:0]            addr;
  logic signed [DATA_W-1:0] row_min_q, col_max_q;
  logic signed [DATA_W-1:0] new_min, new_max;

  logic                     pend_v_r, pend_v_nxt;
  logic signed [DATA_W-1:0] pend_value_r;
  logic [CNT_W-1:0]         pend_row_r, pend_col_r;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_value_r;
  logic [CNT_W-1:0]         out_row_r, out_col_r;
  logic                     out_none_r, out_last_r;
  logic                     take_match, out_load;

  assign ridx = cmd.row_idx[RW-1:0];
  assign cidx = cmd.col_idx[CW-1:0];
  assign addr = AW'(int'(ridx) * MAX_COLS + int'(cidx));

  assign row_min_q = row_min_r[ridx];
  assign col_max_q = col_max_r[cidx];

  // The current row's minimum so far lives in cur_min_r during loading.
  assign new_min = (cmd.first_col || in_element_value < cur_min_r) ? in_element_value
                                                                    : cur_min_r;
  assign new_max = (cmd.first_row || in_element_value > col_max_q) ? in_element_value
                                                                    : col_max_q;

  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      mem[addr]       <= in_element_value;
      row_min_r[ridx] <= new_min;
      col_max_r[cidx] <= new_max;
      cur_min_r       <= new_min;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[addr];
    end
  end

  assign status.match      = (rd_data_r == row_min_q) && (rd_data_r == col_max_q);
  assign status.pend_valid = pend_v_r;
  assign status.out_busy   = out_valid_r && out_stall;

  // A match is held back one step so that the scan's last one can be marked.
  assign take_match = cmd.cmp_take && status.match;
  assign out_load   = (take_match && pend_v_r) || cmd.finish;

  always_comb begin
    pend_v_nxt = pend_v_r;
    if (cmd.scan_start || cmd.finish) begin
      pend_v_nxt = 1'b0;
    end else if (take_match) begin
      pend_v_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_match) begin
      pend_value_r <= rd_data_r;
      pend_row_r   <= CNT_W'(cmd.row_idx) + CNT_W'(1);
      pend_col_r   <= CNT_W'(cmd.col_idx) + CNT_W'(1);
    end
    if (out_load) begin
      if (cmd.finish && !pend_v_r) begin
        out_value_r <= '0;
        out_row_r   <= '0;
        out_col_r   <= '0;
        out_none_r  <= 1'b1;
      end else begin
        out_value_r <= pend_value_r;
        out_row_r   <= pend_row_r;
        out_col_r   <= pend_col_r;
        out_none_r  <= 1'b0;
      end
      out_last_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_value = out_value_r;
  assign out_point_row   = out_row_r;
  assign out_point_col   = out_col_r;
  assign out_none_found  = out_none_r;
  assign out_run_last    = out_last_r;

endmodule

// File: rtl/core/msp_checker.sv
// ----------------------------------------------------------------------------
// msp_checker
// Port-level checks of the saddle point finder, bound to the top level.
// ----------------------------------------------------------------------------
module msp_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              cfg_ready,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [msp_pkg::DATA_W-1:0] out_point_value,
  input logic [msp_pkg::CNT_W-1:0]         out_point_row,
  input logic [msp_pkg::CNT_W-1:0]         out_point_col,
  input logic                              out_none_found,
  input logic                              out_run_last
);
  import msp_pkg::*;

  // A stalled result transaction holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_point_value) &&
      $stable(out_point_row) && $stable(out_point_col) && $stable(out_run_last))
    else $error("stalled result changed");

  // The empty result is always the closing one and carries zero indices.
  a_none_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_none_found |->
      out_run_last && out_point_row == '0 && out_point_col == '0 && out_point_value == '0)
    else $error("malformed none result");

  // A real saddle point carries 1-based indices.
  a_point_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_none_found |-> out_point_row != '0 && out_point_col != '0)
    else $error("saddle point with zero index");

  // The input is held off whenever configuration is closed.
  a_idle_match: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_ready |-> in_stall)
    else $error("input open while configuration is closed");

endmodule

bind matrix_saddle_point_finder msp_checker u_msp_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .cfg_ready       (cfg_ready),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_point_value (out_point_value),
  .out_point_row   (out_point_row),
  .out_point_col   (out_point_col),
  .out_none_found  (out_none_found),
  .out_run_last    (out_run_last)
);
